[sv/array_priority_queue_assert.svh]
// assertion macros shared by the priority queue rtl
`ifndef ARRAY_PRIORITY_QUEUE_ASSERT_SVH
`define ARRAY_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define APQ_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define APQ_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

[sv/apq_pkg.sv]
// ----------------------------------------------------------------------------
// apq_pkg
// types, codes and the entry ordering for the array priority queue
// ----------------------------------------------------------------------------
package apq_pkg;

   // sizing
   localparam int DEPTH_DEFAULT  = 16;
   localparam int CAPACITY_WIDTH = 5;
   localparam int OCC_WIDTH      = 5;
   localparam logic [CAPACITY_WIDTH-1:0] CAPACITY_RESET = 5'd16;

   // operation codes
   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP  = 2'd1;
   localparam logic [1:0] OP_PEEK = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // one stored entry
   typedef struct packed {
      logic [15:0]        tag;
      logic               kind;
      logic [15:0]        time_needed;
      logic signed [15:0] prio;
   } entry_type;

   localparam int ENTRY_WIDTH = $bits(entry_type);

   // request payload
   typedef struct packed {
      logic [1:0]         operation;
      logic [15:0]        tag;
      logic               proc_kind;
      logic [15:0]        time_needed;
      logic signed [15:0] prio;
   } req_type;

   // response payload
   typedef struct packed {
      logic [1:0]           status;
      logic [15:0]          out_tag;
      logic                 out_kind;
      logic [15:0]          out_time;
      logic signed [15:0]   out_prio;
      logic [OCC_WIDTH-1:0] occupancy;
   } rsp_type;

   // scan control from the sequencer
   typedef struct packed {
      logic valid;
      logic first;
   } scan_ctl_type;

   // true when a ranks strictly above b
   function automatic logic better(input entry_type a, input entry_type b);
      logic res;
      if (a.prio != b.prio) begin
         res = (a.prio > b.prio);
      end else if (a.kind != b.kind) begin
         res = (a.kind < b.kind);
      end else begin
         res = (a.time_needed < b.time_needed);
      end
      return res;
   endfunction

endpackage

[sv/apq_ram.sv]
// ----------------------------------------------------------------------------
// apq_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module apq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/apq_scan.sv]
// ----------------------------------------------------------------------------
// apq_scan
// running best-entry tracker fed one ram word per cycle
// ----------------------------------------------------------------------------
module apq_scan #(
   parameter int DEPTH = apq_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  apq_pkg::scan_ctl_type    ctl,
   input  apq_pkg::entry_type       data,
   input  logic [$clog2(DEPTH)-1:0] index,
   output apq_pkg::entry_type       best,
   output logic [$clog2(DEPTH)-1:0] best_idx
);

   apq_pkg::entry_type               best_ff, best_in;
   logic [$clog2(DEPTH)-1:0]         best_idx_ff, best_idx_in;

   // take the first word, then only a strictly better one so ties keep the earliest
   always_comb begin
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      if (ctl.valid && (ctl.first || apq_pkg::better(data, best_ff))) begin
         best_in     = data;
         best_idx_in = index;
      end
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
   end

   assign best     = best_ff;
   assign best_idx = best_idx_ff;

endmodule

[sv/array_priority_queue.sv]
// ----------------------------------------------------------------------------
// array_priority_queue
// bounded priority queue of process entries kept in arrival order in a ram
// ----------------------------------------------------------------------------
//
//   channel   ports                          handshake
//   request   start, busy, req_item          transfer when start && !busy
//   response  rsp_valid, rsp_item            one-cycle strobe, no back-pressure
//   config    csr_valid, csr_ready, csr_data transfer when csr_valid && csr_ready
//
// push, unused code and pop/peek on an empty queue: result in the cycle after the transfer.
// pop/peek: the scan reads the ram once per held entry, then picks the best entry;
// pop then closes the gap by moving each later entry one slot down.
// the pop result is given once the best entry is known; busy holds till the shift ends.
// synchronous reset empties the queue and sets capacity to 16; ram is not cleared.
// the receiver cannot stall, so results never wait.
//
`include "array_priority_queue_assert.svh"

module array_priority_queue #(
   parameter int DEPTH = apq_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  apq_pkg::req_type                     req_item,
   output logic                                 rsp_valid,
   output apq_pkg::rsp_type                     rsp_item,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [apq_pkg::CAPACITY_WIDTH-1:0]   csr_data
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,
      S_WAIT  = 6'b000100,
      S_PICK  = 6'b001000,
      S_SHIFT = 6'b010000,
      S_DRAIN = 6'b100000
   } state_type;

   state_type                           state_ff, state_in;
   logic [IW-1:0]                       ptr_ff, ptr_in;
   logic [CW-1:0]                       count_ff, count_in;
   logic [1:0]                          op_ff, op_in;
   logic                                vld_ff, vld_in;
   logic [IW-1:0]                       idx_ff, idx_in;
   logic [apq_pkg::CAPACITY_WIDTH-1:0]  capacity_ff, capacity_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   apq_pkg::rsp_type                    rsp_ff, rsp_in;

   logic                                accept;
   logic                                full;
   logic                                shift_wr;
   logic                                wr_en;
   logic [IW-1:0]                       wr_addr;
   apq_pkg::entry_type                  wr_data;
   logic                                rd_en;
   logic [apq_pkg::ENTRY_WIDTH-1:0]     rd_data;
   apq_pkg::entry_type                  rd_entry;
   apq_pkg::entry_type                  push_entry;
   apq_pkg::scan_ctl_type               scan_ctl;
   apq_pkg::entry_type                  best;
   logic [IW-1:0]                       best_idx;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rd_entry  = rd_data;

   // effective capacity is the smaller of the register and the depth
   assign full = (32'(count_ff) >= 32'(capacity_ff)) || (32'(count_ff) >= DEPTH);

   always_comb begin
      push_entry.tag         = req_item.tag;
      push_entry.kind        = req_item.proc_kind;
      push_entry.time_needed = req_item.time_needed;
      push_entry.prio        = req_item.prio;
   end

   // a read issued last cycle during the shift is written one slot down
   assign shift_wr = vld_ff && ((state_ff == S_SHIFT) || (state_ff == S_DRAIN));

   // scan sees each word the cycle after its read
   assign scan_ctl.valid = vld_ff && ((state_ff == S_SCAN) || (state_ff == S_WAIT));
   assign scan_ctl.first = (idx_ff == '0);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      vld_in       = 1'b0;
      idx_in       = idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rd_en        = 1'b0;
      wr_en        = shift_wr;
      wr_addr      = idx_ff - IW'(1);
      wr_data      = rd_entry;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_item.operation)
                  apq_pkg::OP_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_in.status = apq_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = IW'(count_ff);
                        wr_data  = push_entry;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  apq_pkg::OP_POP, apq_pkg::OP_PEEK: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = apq_pkg::STATUS_EMPTY;
                     end else begin
                        ptr_in   = '0;
                        op_in    = req_item.operation;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            rd_en  = 1'b1;
            vld_in = 1'b1;
            idx_in = ptr_ff;
            if (CW'(ptr_ff) + CW'(1) == count_ff) begin
               state_in = S_WAIT;
            end else begin
               ptr_in = ptr_ff + IW'(1);
            end
         end
         S_WAIT: begin
            state_in = S_PICK;
         end
         S_PICK: begin
            rsp_valid_in    = 1'b1;
            rsp_in.out_tag  = best.tag;
            rsp_in.out_kind = best.kind;
            rsp_in.out_time = best.time_needed;
            rsp_in.out_prio = best.prio;
            state_in        = S_IDLE;
            if (op_ff == apq_pkg::OP_POP) begin
               count_in = count_ff - CW'(1);
               if (CW'(best_idx) != count_ff - CW'(1)) begin
                  ptr_in   = best_idx + IW'(1);
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            rd_en  = 1'b1;
            vld_in = 1'b1;
            idx_in = ptr_ff;
            if (CW'(ptr_ff) == count_ff) begin
               state_in = S_DRAIN;
            end else begin
               ptr_in = ptr_ff + IW'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // occupancy reports the count after the operation
      rsp_in.occupancy = apq_pkg::OCC_WIDTH'(count_in);
   end

   // configuration register
   always_comb begin
      capacity_in = capacity_ff;
      if (csr_valid && csr_ready) begin
         capacity_in = csr_data;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         capacity_ff  <= apq_pkg::CAPACITY_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
         capacity_ff  <= capacity_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      op_ff  <= op_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // entry storage
   apq_ram #(
      .WIDTH (apq_pkg::ENTRY_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   // best-entry tracker
   apq_scan #(
      .DEPTH (DEPTH)
   ) u_scan (
      .clock    (clock),
      .ctl      (scan_ctl),
      .data     (rd_entry),
      .index    (idx_ff),
      .best     (best),
      .best_idx (best_idx)
   );

   // checks
   `APQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, 32'(count_ff) <= DEPTH,
      "entry count above depth")
   `APQ_ASSERT_NOW(a_shift_addr, clock, reset, shift_wr, CW'(idx_ff) <= count_ff,
      "shift write beyond held entries")
   `APQ_ASSERT_NOW(a_pick_idx, clock, reset, state_ff == S_PICK, CW'(best_idx) < count_ff,
      "best index outside held entries")
   `APQ_ASSERT_NEXT(a_push_rsp, clock, reset,
      accept && (req_item.operation == apq_pkg::OP_PUSH), rsp_valid,
      "push transfer without result")

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the array priority queue: a short directed table,
// then random phases at several capacities and sender idle rates, every
// result compared field by field against a table value or a behavioral queue model
// ----------------------------------------------------------------------------
module testbench;

   localparam int DEPTH        = 16;
   localparam int RANDOM_ITEMS = 1528;
   localparam int PHASES       = 8;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;

   // code the block leaves unused, sent as noise
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // capacity per random phase, the last one is drawn at random
   localparam logic [apq_pkg::CAPACITY_WIDTH-1:0] PHASE_CAPS [PHASES] =
      '{5'd31, 5'd1, 5'd0, 5'd4, 5'd16, 5'd17, 5'd9, 5'd2};
   localparam int IDLE_RATES [3] = '{0, 55, 34};

   // one line of the directed table
   typedef struct {
      bit                                 is_csr;
      logic [apq_pkg::CAPACITY_WIDTH-1:0] csr_value;
      apq_pkg::req_type                   req;
      bit                                 has_known;
      apq_pkg::rsp_type                   known;
   } stim_row_type;

   logic                               clock     = 1'b0;
   logic                               reset     = 1'b1;
   logic                               start     = 1'b0;
   logic                               busy;
   apq_pkg::req_type                   req_item  = '0;
   logic                               rsp_valid;
   apq_pkg::rsp_type                   rsp_item;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [apq_pkg::CAPACITY_WIDTH-1:0] csr_data  = '0;

   // model state and scoreboard
   apq_pkg::entry_type held_entries[$];
   int unsigned        capacity_reg = 16;
   apq_pkg::rsp_type   awaited_rsp[$];
   int                 mismatch_count = 0;
   int                 idle_pct = 0;
   int                 push_pct = 50;
   int                 stall_cycles = 0;
   stim_row_type       script[$];

   always #5 clock = ~clock;

   array_priority_queue #(.DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // ordering key: larger key ranks higher, ties keep the earliest entry
   function automatic logic [32:0] rank_key(input apq_pkg::entry_type e);
      return {~e.prio[15], e.prio[14:0], ~e.kind, ~e.time_needed};
   endfunction

   // apply one request to the queue model and return its result
   function automatic apq_pkg::rsp_type queue_model_apply(input apq_pkg::req_type r);
      apq_pkg::rsp_type   o;
      apq_pkg::entry_type e;
      int unsigned        room;
      int                 best;
      o = '0;
      o.status = apq_pkg::STATUS_OK;
      room = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
      case (r.operation)
         apq_pkg::OP_PUSH: begin
            if (held_entries.size() >= room) begin
               o.status = apq_pkg::STATUS_FULL;
            end else begin
               e.tag         = r.tag;
               e.kind        = r.proc_kind;
               e.time_needed = r.time_needed;
               e.prio        = r.prio;
               held_entries.push_back(e);
            end
         end
         apq_pkg::OP_POP, apq_pkg::OP_PEEK: begin
            if (held_entries.size() == 0) begin
               o.status = apq_pkg::STATUS_EMPTY;
            end else begin
               best = 0;
               for (int i = 1; i < held_entries.size(); i++) begin
                  if (rank_key(held_entries[i]) > rank_key(held_entries[best])) begin
                     best = i;
                  end
               end
               o.out_tag  = held_entries[best].tag;
               o.out_kind = held_entries[best].kind;
               o.out_time = held_entries[best].time_needed;
               o.out_prio = held_entries[best].prio;
               if (r.operation == apq_pkg::OP_POP) begin
                  held_entries.delete(best);
               end
            end
         end
         default: begin
         end
      endcase
      o.occupancy = apq_pkg::OCC_WIDTH'(held_entries.size());
      return o;
   endfunction

   function automatic apq_pkg::req_type make_req(input logic [1:0] op,
                                                 input logic [15:0] tag,
                                                 input logic kind, input logic [15:0] tn,
                                                 input logic [15:0] prio);
      apq_pkg::req_type r;
      r.operation   = op;
      r.tag         = tag;
      r.proc_kind   = kind;
      r.time_needed = tn;
      r.prio        = prio;
      return r;
   endfunction

   function automatic apq_pkg::rsp_type make_rsp(input logic [1:0] st,
                                                 input logic [15:0] tag,
                                                 input logic kind, input logic [15:0] tn,
                                                 input logic [15:0] prio,
                                                 input logic [4:0] occ);
      apq_pkg::rsp_type w;
      w.status    = st;
      w.out_tag   = tag;
      w.out_kind  = kind;
      w.out_time  = tn;
      w.out_prio  = prio;
      w.occupancy = occ;
      return w;
   endfunction

   function automatic stim_row_type item_row(input apq_pkg::req_type r);
      stim_row_type s;
      s.is_csr    = 1'b0;
      s.csr_value = '0;
      s.req       = r;
      s.has_known = 1'b0;
      s.known     = '0;
      return s;
   endfunction

   function automatic stim_row_type known_row(input apq_pkg::req_type r,
                                              input apq_pkg::rsp_type w);
      stim_row_type s;
      s           = item_row(r);
      s.has_known = 1'b1;
      s.known     = w;
      return s;
   endfunction

   function automatic stim_row_type csr_row(input logic [apq_pkg::CAPACITY_WIDTH-1:0] v);
      stim_row_type s;
      s           = item_row('0);
      s.is_csr    = 1'b1;
      s.csr_value = v;
      return s;
   endfunction

   // random request, mostly well formed with frequent ranking ties
   function automatic apq_pkg::req_type random_req();
      apq_pkg::req_type r;
      int               roll;
      r.tag         = 16'($urandom);
      r.proc_kind   = 1'($urandom_range(1));
      r.time_needed = ($urandom_range(1) == 1) ? 16'($urandom) : 16'($urandom_range(3));
      case ($urandom_range(4))
         0: r.prio = 16'($urandom);
         1: r.prio = 16'h7fff;
         2: r.prio = 16'h8000;
         default: r.prio = 16'($urandom_range(3)) - 16'd1;
      endcase
      roll = $urandom_range(99);
      if (roll < push_pct) begin
         r.operation = apq_pkg::OP_PUSH;
      end else if (roll < push_pct + 4) begin
         r.operation = OP_UNUSED;
      end else if ($urandom_range(3) == 0) begin
         r.operation = apq_pkg::OP_PEEK;
      end else begin
         r.operation = apq_pkg::OP_POP;
      end
      return r;
   endfunction

   task automatic compare_field(input string what, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
      end
   endtask

   // present one request, record its expected result at the transfer
   task automatic send_item(input apq_pkg::req_type r, input bit use_known,
                            input apq_pkg::rsp_type known);
      apq_pkg::rsp_type predicted;
      req_item <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      predicted = queue_model_apply(r);
      awaited_rsp.push_back(use_known ? known : predicted);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // stop sending and wait for the block to go idle
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (awaited_rsp.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [apq_pkg::CAPACITY_WIDTH-1:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      capacity_reg = 32'(value);
   endtask

   // result checking and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
         if (rsp_valid) begin
            if (awaited_rsp.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: result expected none, got %0h", $time, rsp_item);
            end else begin
               apq_pkg::rsp_type want;
               want = awaited_rsp.pop_front();
               compare_field("status", 16'(want.status), 16'(rsp_item.status));
               compare_field("out_tag", want.out_tag, rsp_item.out_tag);
               compare_field("out_kind", 16'(want.out_kind), 16'(rsp_item.out_kind));
               compare_field("out_time", want.out_time, rsp_item.out_time);
               compare_field("out_prio", want.out_prio, rsp_item.out_prio);
               compare_field("occupancy", 16'(want.occupancy), 16'(rsp_item.occupancy));
            end
         end
      end
   end

   // stimulus
   initial begin
      // directed table: empty queue, extremes, each ranking tie, full cases
      script.push_back(known_row(make_req(apq_pkg::OP_POP, 16'h0, 1'b0, 16'h0, 16'h0),
                                 make_rsp(apq_pkg::STATUS_EMPTY, 16'h0, 1'b0, 16'h0,
                                          16'h0, 5'd0)));
      script.push_back(known_row(make_req(apq_pkg::OP_PEEK, 16'hffff, 1'b1, 16'hffff,
                                          16'hffff),
                                 make_rsp(apq_pkg::STATUS_EMPTY, 16'h0, 1'b0, 16'h0,
                                          16'h0, 5'd0)));
      script.push_back(known_row(make_req(OP_UNUSED, 16'hffff, 1'b1, 16'hffff, 16'hffff),
                                 make_rsp(apq_pkg::STATUS_OK, 16'h0, 1'b0, 16'h0,
                                          16'h0, 5'd0)));
      script.push_back(known_row(make_req(apq_pkg::OP_PUSH, 16'hffff, 1'b1, 16'hffff,
                                          16'h7fff),
                                 make_rsp(apq_pkg::STATUS_OK, 16'h0, 1'b0, 16'h0,
                                          16'h0, 5'd1)));
      script.push_back(known_row(make_req(apq_pkg::OP_PUSH, 16'h0, 1'b0, 16'h0, 16'h8000),
                                 make_rsp(apq_pkg::STATUS_OK, 16'h0, 1'b0, 16'h0,
                                          16'h0, 5'd2)));
      script.push_back(known_row(make_req(apq_pkg::OP_PEEK, 16'h0, 1'b0, 16'h0, 16'h0),
                                 make_rsp(apq_pkg::STATUS_OK, 16'hffff, 1'b1, 16'hffff,
                                          16'h7fff, 5'd2)));
      // system beats user at equal priority
      script.push_back(item_row(make_req(apq_pkg::OP_PUSH, 16'h1234, 1'b0, 16'd10,
                                         16'h7fff)));
      script.push_back(item_row(make_req(apq_pkg::OP_PEEK, 16'h0, 1'b0, 16'h0, 16'h0)));
      // shorter time wins, then the earliest of two equal entries
      script.push_back(item_row(make_req(apq_pkg::OP_PUSH, 16'h0002, 1'b0, 16'd5,
                                         16'h7fff)));
      script.push_back(item_row(make_req(apq_pkg::OP_PUSH, 16'h0003, 1'b0, 16'd5,
                                         16'h7fff)));
      script.push_back(item_row(make_req(apq_pkg::OP_POP, 16'h0, 1'b0, 16'h0, 16'h0)));
      script.push_back(item_row(make_req(apq_pkg::OP_POP, 16'h0, 1'b0, 16'h0, 16'h0)));
      script.push_back(item_row(make_req(apq_pkg::OP_POP, 16'h0, 1'b0, 16'h0, 16'h0)));
      script.push_back(item_row(make_req(OP_UNUSED, 16'h5a5a, 1'b0, 16'h0, 16'h0)));
      script.push_back(item_row(make_req(apq_pkg::OP_POP, 16'h0, 1'b0, 16'h0, 16'h0)));
      script.push_back(known_row(make_req(apq_pkg::OP_POP, 16'h0, 1'b0, 16'h0, 16'h0),
                                 make_rsp(apq_pkg::STATUS_OK, 16'h0, 1'b0, 16'h0,
                                          16'h8000, 5'd0)));
      script.push_back(known_row(make_req(apq_pkg::OP_POP, 16'h0, 1'b0, 16'h0, 16'h0),
                                 make_rsp(apq_pkg::STATUS_EMPTY, 16'h0, 1'b0, 16'h0,
                                          16'h0, 5'd0)));
      // smallest capacities report full
      script.push_back(csr_row(5'd1));
      script.push_back(known_row(make_req(apq_pkg::OP_PUSH, 16'h00aa, 1'b1, 16'd1, 16'd1),
                                 make_rsp(apq_pkg::STATUS_OK, 16'h0, 1'b0, 16'h0,
                                          16'h0, 5'd1)));
      script.push_back(known_row(make_req(apq_pkg::OP_PUSH, 16'h00bb, 1'b0, 16'd2, 16'd2),
                                 make_rsp(apq_pkg::STATUS_FULL, 16'h0, 1'b0, 16'h0,
                                          16'h0, 5'd1)));
      script.push_back(csr_row(5'd0));
      script.push_back(known_row(make_req(apq_pkg::OP_PUSH, 16'h00cc, 1'b0, 16'd3, 16'd3),
                                 make_rsp(apq_pkg::STATUS_FULL, 16'h0, 1'b0, 16'h0,
                                          16'h0, 5'd1)));
      script.push_back(item_row(make_req(apq_pkg::OP_PEEK, 16'h0, 1'b0, 16'h0, 16'h0)));
      // capacity above the depth is clamped
      script.push_back(csr_row(5'd31));
      script.push_back(item_row(make_req(apq_pkg::OP_POP, 16'h0, 1'b0, 16'h0, 16'h0)));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[k]) begin
         if (script[k].is_csr) begin
            wait_drained();
            write_capacity(script[k].csr_value);
         end else begin
            send_item(script[k].req, script[k].has_known, script[k].known);
         end
      end

      // random phases, the queue keeps its entries across capacity changes
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         if (ph == PHASES - 1) begin
            write_capacity(apq_pkg::CAPACITY_WIDTH'($urandom_range(31)));
         end else begin
            write_capacity(PHASE_CAPS[ph]);
         end
         idle_pct = IDLE_RATES[ph % 3];
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            // every 24 items pick a filling, balanced or draining stretch at random
            if (n % 24 == 0) begin
               case ($urandom_range(2))
                  0: push_pct = 80;
                  1: push_pct = 50;
                  default: push_pct = 25;
               endcase
            end
            send_item(random_req(), 1'b0, '0);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_rsp.size() != 0) begin
         mismatch_count++;
         $display("%0t ns: results expected %0d more, got none", $time, awaited_rsp.size());
      end
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
